// ===== src/rmq_pkg.sv =====
package rmq_pkg;

  localparam int EW   = 16;
  localparam int FB   = 14;
  localparam int QW   = FB + 2;
  localparam int VW   = EW + 4;
  localparam int MW   = VW - 1;
  localparam int NW   = 31;
  localparam int PW   = 5;
  localparam int SQW  = 2 * NW;
  localparam int SUMW = 64;
  localparam int RW   = 32;
  localparam int QB   = FB + 1;
  localparam int NUMW = RW + QB;

  localparam logic [1:0] LEAD_X = 2'd0;
  localparam logic [1:0] LEAD_Y = 2'd1;
  localparam logic [1:0] LEAD_Z = 2'd2;

  localparam logic signed [VW-1:0] ONE_V = VW'(2 ** FB);
  localparam logic signed [QW-1:0] ONE_Q = QW'(2 ** FB);

  typedef struct packed {
    logic signed [EW-1:0] m00;
    logic signed [EW-1:0] m01;
    logic signed [EW-1:0] m02;
    logic signed [EW-1:0] m10;
    logic signed [EW-1:0] m11;
    logic signed [EW-1:0] m12;
    logic signed [EW-1:0] m20;
    logic signed [EW-1:0] m21;
    logic signed [EW-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic                 degenerate;
  } quat_t;

  typedef struct packed {
    logic              deg;
    logic [3:0][VW-1:0] q;
  } vec_t;

  typedef struct packed {
    logic              deg;
    logic [3:0]        neg;
    logic [3:0][NW-1:0] mag;
  } mag_t;

  typedef struct packed {
    mag_t               base;
    logic [3:0][SQW-1:0] sq;
  } sq_t;

  typedef struct packed {
    mag_t            base;
    logic [SUMW-1:0] s;
    logic [SUMW-1:0] r;
  } sum_t;

  typedef struct packed {
    mag_t          base;
    logic [RW-1:0] n;
  } root_t;

  typedef struct packed {
    logic                deg;
    logic [3:0]          neg;
    logic [RW-1:0]       n;
    logic [3:0][NUMW-1:0] rem;
    logic [3:0][QB-1:0]   qv;
  } div_t;

endpackage

// ===== src/rmq_front.sv =====
module rmq_front import rmq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic mat_valid,
  output logic mat_stall,
  input  mat_t mat,
  output logic sum_valid,
  input  logic sum_stall,
  output sum_t sum
);

  logic [3:0] v;
  logic [3:0] go;
  vec_t s1, s1_next;
  mag_t s2, s2_next;
  sq_t  s3, s3_next;
  sum_t s4, s4_next;

  always_comb begin
    go[3] = !v[3] || !sum_stall;
    go[2] = !v[2] || go[3];
    go[1] = !v[1] || go[2];
    go[0] = !v[0] || go[1];
  end

  assign mat_stall = !go[0];
  assign sum_valid = v[3];
  assign sum       = s4;

  // pick leading component and form the proportional vector
  always_comb begin
    logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [VW-1:0] trace, arg, q0, q1, q2, q3;
    logic [1:0] lead;
    e00 = VW'(mat.m00); e01 = VW'(mat.m01); e02 = VW'(mat.m02);
    e10 = VW'(mat.m10); e11 = VW'(mat.m11); e12 = VW'(mat.m12);
    e20 = VW'(mat.m20); e21 = VW'(mat.m21); e22 = VW'(mat.m22);
    trace = e00 + e11 + e22;
    lead  = LEAD_X;
    arg = '0; q0 = '0; q1 = '0; q2 = '0; q3 = '0;
    if (trace > 0) begin
      arg = trace + ONE_V;
      q0  = arg;
      q1  = e21 - e12;
      q2  = e02 - e20;
      q3  = e10 - e01;
    end else begin
      if (e11 > e00) lead = LEAD_Y;
      if (e22 > ((lead == LEAD_Y) ? e11 : e00)) lead = LEAD_Z;
      case (lead)
        LEAD_X: begin
          arg = e00 - e11 - e22 + ONE_V;
          q1  = arg;
          q0  = e21 - e12;
          q2  = e10 + e01;
          q3  = e20 + e02;
        end
        LEAD_Y: begin
          arg = e11 - e22 - e00 + ONE_V;
          q2  = arg;
          q0  = e02 - e20;
          q3  = e21 + e12;
          q1  = e01 + e10;
        end
        LEAD_Z: begin
          arg = e22 - e00 - e11 + ONE_V;
          q3  = arg;
          q0  = e10 - e01;
          q1  = e02 + e20;
          q2  = e12 + e21;
        end
        default: begin
          arg = '0;
        end
      endcase
    end
    s1_next.deg  = (arg <= 0);
    s1_next.q[0] = q0;
    s1_next.q[1] = q1;
    s1_next.q[2] = q2;
    s1_next.q[3] = q3;
  end

  // magnitudes and common left shift to put the largest in [2^30, 2^31)
  always_comb begin
    logic signed [VW-1:0] qs, qa;
    logic [3:0][MW-1:0] m;
    logic [MW-1:0] big;
    logic [PW-1:0] pos, sh;
    big = '0;
    pos = '0;
    for (int t = 0; t < 4; t++) begin
      qs = $signed(s1.q[t]);
      qa = qs[VW-1] ? -qs : qs;
      m[t] = qa[MW-1:0];
      s2_next.neg[t] = qs[VW-1];
      if (m[t] > big) big = m[t];
    end
    for (int b = 0; b < MW; b++) begin
      if (big[b]) pos = PW'(b);
    end
    sh = PW'(NW - 1) - pos;
    s2_next.deg = s1.deg || (big == '0);
    for (int t = 0; t < 4; t++) begin
      s2_next.mag[t] = s2_next.deg ? '0 : (NW'(m[t]) << sh);
    end
  end

  always_comb begin
    logic [SQW-1:0] me;
    s3_next.base = s2;
    for (int t = 0; t < 4; t++) begin
      me = SQW'(s2.mag[t]);
      s3_next.sq[t] = me * me;
    end
  end

  always_comb begin
    s4_next.base = s3.base;
    s4_next.s    = SUMW'(s3.sq[0]) + SUMW'(s3.sq[1]) + SUMW'(s3.sq[2]) + SUMW'(s3.sq[3]);
    s4_next.r    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[0]) v[0] <= mat_valid;
      if (go[1]) v[1] <= v[0];
      if (go[2]) v[2] <= v[1];
      if (go[3]) v[3] <= v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) s1 <= s1_next;
    if (go[1]) s2 <= s2_next;
    if (go[2]) s3 <= s3_next;
    if (go[3]) s4 <= s4_next;
  end

endmodule

// ===== src/rmq_sqrt.sv =====
module rmq_sqrt import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  sum_valid,
  output logic  sum_stall,
  input  sum_t  sum,
  output logic  root_valid,
  input  logic  root_stall,
  output root_t root
);

  logic [RW-1:0] v;
  logic [RW-1:0] go;
  sum_t st [RW];

  always_comb begin
    go[RW-1] = !v[RW-1] || !root_stall;
    for (int k = RW - 2; k >= 0; k--) begin
      go[k] = !v[k] || go[k+1];
    end
  end

  assign sum_stall  = !go[0];
  assign root_valid = v[RW-1];
  assign root.base  = st[RW-1].base;
  assign root.n     = st[RW-1].r[RW-1:0];

  // one result bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_st
    localparam logic [SUMW-1:0] BIT = SUMW'(1) << (SUMW - 2 - 2 * k);
    sum_t src, st_next;
    logic src_v;
    if (k == 0) begin : g_first
      assign src   = sum;
      assign src_v = sum_valid;
    end else begin : g_rest
      assign src   = st[k-1];
      assign src_v = v[k-1];
    end
    always_comb begin
      st_next = src;
      if (src.s >= src.r + BIT) begin
        st_next.s = src.s - (src.r + BIT);
        st_next.r = (src.r >> 1) + BIT;
      end else begin
        st_next.r = src.r >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (go[k]) begin
        v[k] <= src_v;
      end
    end
    always_ff @(posedge clk) begin
      if (go[k]) st[k] <= st_next;
    end
  end

endmodule

// ===== src/rmq_div.sv =====
module rmq_div import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  root_valid,
  output logic  root_stall,
  input  root_t root,
  output logic  quat_valid,
  input  logic  quat_stall,
  output quat_t quat
);

  localparam int NS = QB + 2;

  logic [NS-1:0] v;
  logic [NS-1:0] go;
  div_t  dv [QB+1];
  div_t  d0_next;
  quat_t q_reg, q_next;

  always_comb begin
    go[NS-1] = !v[NS-1] || !quat_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      go[k] = !v[k] || go[k+1];
    end
  end

  assign root_stall = !go[0];
  assign quat_valid = v[NS-1];
  assign quat       = q_reg;

  // numerator with half the divisor for round half up
  always_comb begin
    d0_next.deg = root.base.deg;
    d0_next.neg = root.base.neg;
    d0_next.n   = root.n;
    for (int t = 0; t < 4; t++) begin
      d0_next.rem[t] = (NUMW'(root.base.mag[t]) << FB) + NUMW'(root.n >> 1);
      d0_next.qv[t]  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) dv[0] <= d0_next;
  end

  // one quotient bit per stage, four lanes
  for (genvar k = 1; k <= QB; k++) begin : g_st
    localparam int P = QB - k;
    div_t nx;
    always_comb begin
      logic [NUMW-1:0] d;
      d  = NUMW'(dv[k-1].n) << P;
      nx = dv[k-1];
      for (int t = 0; t < 4; t++) begin
        if (dv[k-1].rem[t] >= d) begin
          nx.rem[t]   = dv[k-1].rem[t] - d;
          nx.qv[t][P] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (go[k]) dv[k] <= nx;
    end
  end

  always_comb begin
    logic [3:0][QW-1:0] r;
    logic [QW-1:0] u;
    for (int t = 0; t < 4; t++) begin
      u    = QW'(dv[QB].qv[t]);
      r[t] = dv[QB].deg ? '0 : (dv[QB].neg[t] ? -u : u);
    end
    q_next.quat_w     = r[0];
    q_next.quat_x     = r[1];
    q_next.quat_y     = r[2];
    q_next.quat_z     = r[3];
    q_next.degenerate = dv[QB].deg;
  end

  always_ff @(posedge clk) begin
    if (go[NS-1]) q_reg <= q_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (go[k]) v[k] <= (k == 0) ? root_valid : v[k-1];
      end
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    quat_valid && quat.degenerate |->
      quat.quat_w == '0 && quat.quat_x == '0 && quat.quat_y == '0 && quat.quat_z == '0)
    else $error("degenerate beat with nonzero quaternion");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    quat_valid |->
      quat.quat_w <= ONE_Q && quat.quat_w >= -ONE_Q &&
      quat.quat_x <= ONE_Q && quat.quat_x >= -ONE_Q &&
      quat.quat_y <= ONE_Q && quat.quat_y >= -ONE_Q &&
      quat.quat_z <= ONE_Q && quat.quat_z >= -ONE_Q)
    else $error("quaternion component out of unit range");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    root_valid && !root.base.deg |->
      root.n >= RW'(root.base.mag[0]) && root.n >= RW'(root.base.mag[1]) &&
      root.n >= RW'(root.base.mag[2]) && root.n >= RW'(root.base.mag[3]))
    else $error("root below a component magnitude");

endmodule

// ===== src/rotation_matrix_to_quaternion.sv =====
// channel   signals                          beat
// mat       mat_valid, mat_stall, mat        nine matrix elements, Q2.14
// quat      quat_valid, quat_stall, quat     w, x, y, z in Q2.14, degenerate flag
//
// one beat per cycle in, one beat per cycle out while quat_stall is low
// pipeline: 4 front stages, 32 square root stages (one bit each), 17 divide stages
// reset clears every valid bit; payload registers are not reset
// each stage holds while the next is full and stalled, bubbles fill in behind
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  mat_valid,
  output logic  mat_stall,
  input  mat_t  mat,
  output logic  quat_valid,
  input  logic  quat_stall,
  output quat_t quat
);

  logic  sum_valid, sum_stall;
  sum_t  sum;
  logic  root_valid, root_stall;
  root_t root;

  rmq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .mat_valid (mat_valid),
    .mat_stall (mat_stall),
    .mat       (mat),
    .sum_valid (sum_valid),
    .sum_stall (sum_stall),
    .sum       (sum)
  );

  rmq_sqrt u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .sum_valid  (sum_valid),
    .sum_stall  (sum_stall),
    .sum        (sum),
    .root_valid (root_valid),
    .root_stall (root_stall),
    .root       (root)
  );

  rmq_div u_div (
    .clk        (clk),
    .rst        (rst),
    .root_valid (root_valid),
    .root_stall (root_stall),
    .root       (root),
    .quat_valid (quat_valid),
    .quat_stall (quat_stall),
    .quat       (quat)
  );

endmodule

// ===== sim/quat_checker.sv =====
module quat_checker import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  mat_valid,
  input  logic  mat_stall,
  input  mat_t  mat,
  input  logic  quat_valid,
  input  logic  quat_stall,
  input  quat_t quat,
  output int    fail_count,
  output int    pending
);

  quat_t expected_quats[$];

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic quat_t matrix_to_quat(mat_t a);
    longint m [3][3];
    longint q [4];
    longint unsigned mag [4];
    longint unsigned big, sum, n, v;
    longint tr, arg, one;
    int i, j, k;
    quat_t res;
    m[0][0] = a.m00; m[0][1] = a.m01; m[0][2] = a.m02;
    m[1][0] = a.m10; m[1][1] = a.m11; m[1][2] = a.m12;
    m[2][0] = a.m20; m[2][1] = a.m21; m[2][2] = a.m22;
    one = 64'sd1 << FB;
    res = '0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      arg = tr + one;
      q[0] = arg;
      q[1] = m[2][1] - m[1][2];
      q[2] = m[0][2] - m[2][0];
      q[3] = m[1][0] - m[0][1];
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      arg = m[i][i] - m[j][j] - m[k][k] + one;
      q[1+i] = arg;
      q[0] = m[k][j] - m[j][k];
      q[1+j] = m[j][i] + m[i][j];
      q[1+k] = m[k][i] + m[i][k];
    end
    big = 0;
    for (int t = 0; t < 4; t++) begin
      mag[t] = q[t] < 0 ? -q[t] : q[t];
      if (mag[t] > big) big = mag[t];
    end
    if (arg <= 0 || big == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    while (big >= (64'd1 << 31)) begin
      big = big >> 1;
      for (int t = 0; t < 4; t++) mag[t] = mag[t] >> 1;
    end
    while (big < (64'd1 << 30)) begin
      big = big << 1;
      for (int t = 0; t < 4; t++) mag[t] = mag[t] << 1;
    end
    sum = 0;
    for (int t = 0; t < 4; t++) sum = sum + mag[t] * mag[t];
    n = int_sqrt(sum);
    for (int t = 0; t < 4; t++) begin
      v = ((mag[t] << FB) + (n >> 1)) / n;
      if (q[t] < 0) v = -v;
      case (t)
        0: res.quat_w = v[QW-1:0];
        1: res.quat_x = v[QW-1:0];
        2: res.quat_y = v[QW-1:0];
        default: res.quat_z = v[QW-1:0];
      endcase
    end
    return res;
  endfunction

  assign pending = expected_quats.size();

  always @(posedge clk) begin
    quat_t e;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (mat_valid && !mat_stall) expected_quats.push_back(matrix_to_quat(mat));
      if (quat_valid && !quat_stall) begin
        if (expected_quats.size() == 0) begin
          $error("quat beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_quats.pop_front();
          if (quat !== e) begin
            if (quat.quat_w !== e.quat_w)
              $error("quat_w expected %0d actual %0d", e.quat_w, quat.quat_w);
            if (quat.quat_x !== e.quat_x)
              $error("quat_x expected %0d actual %0d", e.quat_x, quat.quat_x);
            if (quat.quat_y !== e.quat_y)
              $error("quat_y expected %0d actual %0d", e.quat_y, quat.quat_y);
            if (quat.quat_z !== e.quat_z)
              $error("quat_z expected %0d actual %0d", e.quat_z, quat.quat_z);
            if (quat.degenerate !== e.degenerate)
              $error("degenerate expected %0b actual %0b", e.degenerate, quat.degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import rmq_pkg::*;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  mat_valid = 1'b0;
  logic  mat_stall;
  mat_t  mat = '0;
  logic  quat_valid;
  logic  quat_stall = 1'b0;
  quat_t quat;
  int    fail_count;
  int    pending;
  bit    hold_off = 1'b0;
  bit    no_idle = 1'b0;

  localparam logic signed [EW-1:0] ONE_E = EW'(2 ** FB);

  always #5 clk = ~clk;

  rotation_matrix_to_quaternion DUT (.*);

  quat_checker u_checker (.*);

  function automatic logic [EW-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return EW'($urandom());
      1: return EW'($signed($urandom_range(0, 2 * 16384)) - 16384);
      2: return EW'($signed($urandom_range(0, 400)) - 200);
      3: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return EW'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic mat_t rand_mat();
    mat_t a;
    int s;
    a = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
         rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    if ($urandom_range(0, 3) == 0) begin
      s = $urandom_range(0, 2);
      a.m00 = s == 0 ? ONE_E : -ONE_E;
      a.m11 = s == 1 ? ONE_E : -ONE_E;
      a.m22 = s == 2 ? ONE_E : -ONE_E;
    end
    return a;
  endfunction

  task automatic send_mat(mat_t a, bit gaps);
    if (gaps) begin
      while ($urandom_range(0, 99) < 14) begin
        mat_valid <= 1'b0;
        @(posedge clk);
      end
    end
    mat_valid <= 1'b1;
    mat <= a;
    @(posedge clk);
    while (mat_stall) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) quat_stall <= 1'b0;
    else if (hold_off) quat_stall <= 1'b1;
    else if (no_idle) quat_stall <= 1'b0;
    else quat_stall <= ($urandom_range(0, 99) < 14);
  end

  initial begin
    mat_t d [$];
    int wait_n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    d.push_back('0);
    d.push_back({ONE_E, 16'd0, 16'd0, 16'd0, ONE_E, 16'd0, 16'd0, 16'd0, ONE_E});
    d.push_back({-ONE_E, 16'd0, 16'd0, 16'd0, -ONE_E, 16'd0, 16'd0, 16'd0, ONE_E});
    d.push_back({-ONE_E, 16'd0, 16'd0, 16'd0, ONE_E, 16'd0, 16'd0, 16'd0, -ONE_E});
    d.push_back({ONE_E, 16'd0, 16'd0, 16'd0, -ONE_E, 16'd0, 16'd0, 16'd0, -ONE_E});
    d.push_back({9{16'h7fff}});
    d.push_back({9{16'h8000}});
    d.push_back({9{16'hffff}});
    d.push_back({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                 16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    d.push_back({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    d.push_back({16'd0, -ONE_E, 16'd0, ONE_E, 16'd0, 16'd0, 16'd0, 16'd0, ONE_E});
    d.push_back({16'd100, 16'd5, 16'd7, 16'd3, 16'd100, 16'd9, 16'd2, 16'd4, -16'd300});
    d.push_back({-16'd8192, 16'd1, 16'd2, 16'd3, -16'd8192, 16'd4, 16'd5, 16'd6, -16'd8192});
    d.push_back({16'd1, 16'd0, 16'd0, 16'd0, -16'd1, 16'd0, 16'd0, 16'd0, 16'd0});
    d.push_back({-16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    d.push_back({-16'd12000, 16'd0, 16'd0, 16'd0, 16'd4000, 16'd0, 16'd0, 16'd0, 16'd4000});
    foreach (d[i]) send_mat(d[i], 1'b1);
    for (int i = 0; i < 850; i++) begin
      if (i == 150) begin
        mat_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (i == 300) begin
        hold_off = 1'b1;
        fork
          begin
            wait_n = 0;
            while (wait_n < 200) begin
              @(posedge clk);
              wait_n++;
            end
            hold_off = 1'b0;
          end
        join_none
      end
      no_idle = (i >= 400 && i < 700);
      send_mat(rand_mat(), !(i >= 400 && i < 700));
    end
    no_idle = 1'b0;
    mat_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
